// ----- hw/rtl/mps_pkg.sv -----
// Shared constants, register codes and types for the masked pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

    localparam int WIN_DEPTH  = 16;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 5;
    localparam int SKIP_W     = 16;
    localparam int CNT_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SHIFT_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_PATTERN_LEN  = 3'd3,
        CFG_SKIP_COUNT   = 3'd4,
        CFG_BASE_ADDRESS = 3'd5
    } cfg_reg_e;

    // Pattern and care mask are aligned to the window: position k of the
    // window faces byte k of pattern, and unused positions have care cleared.
    typedef struct packed {
        logic [WIN_DEPTH*BYTE_W-1:0] pattern;
        logic [WIN_DEPTH-1:0]        care;
        logic [LEN_W-1:0]            len;
        logic [SKIP_W-1:0]           skip;
        logic [ADDR_W-1:0]           base;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mps_cfg.sv -----
// Configuration registers and the window alignment of pattern and care mask.
`timescale 1ns / 1ps
`default_nettype none

module mps_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mps_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output mps_pkg::cfg_t                            cfg
);

    logic [2*64-1:0]                 pattern_reg;
    logic [mps_pkg::WIN_DEPTH-1:0]   care_reg;
    logic [mps_pkg::LEN_W-1:0]       len_reg;
    logic [mps_pkg::SKIP_W-1:0]      skip_reg;
    logic [mps_pkg::ADDR_W-1:0]      base_reg;

    logic [mps_pkg::LEN_W-1:0]       eff_len;
    logic [mps_pkg::SHIFT_W-1:0]     shift_amt;
    logic [mps_pkg::WIN_DEPTH:0]     len_mask;
    logic [mps_pkg::WIN_DEPTH-1:0]   care_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            care_reg    <= '1;
            len_reg     <= mps_pkg::LEN_W'(mps_pkg::WIN_DEPTH);
            skip_reg    <= '0;
            base_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mps_pkg::CFG_PATTERN_LOW:  pattern_reg[63:0]   <= cfg_wr_data;
                mps_pkg::CFG_PATTERN_HIGH: pattern_reg[127:64] <= cfg_wr_data;
                mps_pkg::CFG_CARE_MASK:    care_reg <= cfg_wr_data[mps_pkg::WIN_DEPTH-1:0];
                mps_pkg::CFG_PATTERN_LEN:  len_reg  <= cfg_wr_data[mps_pkg::LEN_W-1:0];
                mps_pkg::CFG_SKIP_COUNT:   skip_reg <= cfg_wr_data[mps_pkg::SKIP_W-1:0];
                mps_pkg::CFG_BASE_ADDRESS: base_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // A length of zero acts as one; anything above the window size saturates.
    always_comb begin
        if (len_reg == '0) begin
            eff_len = mps_pkg::LEN_W'(1);
        end else if (len_reg > mps_pkg::LEN_W'(mps_pkg::WIN_DEPTH)) begin
            eff_len = mps_pkg::LEN_W'(mps_pkg::WIN_DEPTH);
        end else begin
            eff_len = len_reg;
        end
    end

    assign shift_amt = mps_pkg::SHIFT_W'(mps_pkg::LEN_W'(mps_pkg::WIN_DEPTH) - eff_len);
    assign len_mask  = ((mps_pkg::WIN_DEPTH+1)'(1) << eff_len) - (mps_pkg::WIN_DEPTH+1)'(1);
    assign care_used = care_reg & len_mask[mps_pkg::WIN_DEPTH-1:0];

    assign cfg.pattern = pattern_reg << {shift_amt, 3'b000};
    assign cfg.care    = care_used << shift_amt;
    assign cfg.len     = eff_len;
    assign cfg.skip    = skip_reg;
    assign cfg.base    = base_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mps_cell.sv -----
// One window cell: holds a byte, passes it down the chain and compares it.
`timescale 1ns / 1ps
`default_nettype none

module mps_cell (
    input  wire logic                          aclk,
    input  wire logic                          shift_en,
    input  wire logic [mps_pkg::BYTE_W-1:0]    byte_in,
    input  wire logic [mps_pkg::BYTE_W-1:0]    pat_byte,
    input  wire logic                          care_bit,
    output logic      [mps_pkg::BYTE_W-1:0]    byte_out,
    output logic                               hit
);

    logic [mps_pkg::BYTE_W-1:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = ~care_bit | (byte_reg == pat_byte);

endmodule

`default_nettype wire

// ----- hw/rtl/masked_pattern_scanner.sv -----
// Top level of the masked byte signature scanner.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte per beat and can accept a beat on every clock cycle unless
// stalled by m_tready. Each accepted byte enters a chain of sixteen cells that
// shift one place per beat; the cells compare their bytes with the pattern in
// parallel, and a decision stage counts matches and reports the wanted one, or
// not found on the last byte of the region. A byte is registered in the cells
// and the first stage, then the decision stage writes its result beat into the
// output register, which lets the next byte in while a result waits for
// m_tready. Configuration writes must be made only while no byte is in flight,
// which the block does not enforce; they apply to the next accepted byte.
module masked_pattern_scanner (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mps_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // data_byte
    input  wire logic                              s_tlast,   // last_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [63:0]                            m_tdata,   // match_address
    output logic                                   m_tuser    // found
);

    mps_pkg::cfg_t cfg;

    logic s_accept;
    logic s2_fire;

    logic                          flush_reg;
    logic [mps_pkg::ADDR_W-1:0]    bytes_seen_reg;
    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic                          s1_pos_ok_reg;
    logic [mps_pkg::ADDR_W-1:0]    s1_off_reg;

    logic [mps_pkg::CNT_W-1:0]     matches_reg;
    logic [mps_pkg::CNT_W-1:0]     matches_next;
    logic                          done_reg;
    logic                          done_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          m_found_reg;
    logic                          m_found_next;
    logic [mps_pkg::ADDR_W-1:0]    m_addr_reg;
    logic [mps_pkg::ADDR_W-1:0]    m_addr_next;

    logic [mps_pkg::BYTE_W-1:0]    win [mps_pkg::WIN_DEPTH];
    logic [mps_pkg::WIN_DEPTH-1:0] cell_hit;

    logic window_hit;
    logic take;
    logic not_found;

    mps_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    assign s2_fire  = s1_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | s2_fire;
    assign s_accept = s_tvalid & s_tready;

    // The cell chain. After the last byte of a region the chain takes in
    // zeros behind the new byte, so the next region starts from a clear window.
    for (genvar k = 0; k < mps_pkg::WIN_DEPTH; k++) begin : g_cell
        logic [mps_pkg::BYTE_W-1:0] cell_in;

        if (k == mps_pkg::WIN_DEPTH - 1) begin : g_head
            assign cell_in = s_tdata;
        end else begin : g_body
            assign cell_in = flush_reg ? '0 : win[k+1];
        end

        mps_cell u_cell (
            .aclk     (aclk),
            .shift_en (s_accept),
            .byte_in  (cell_in),
            .pat_byte (cfg.pattern[k*mps_pkg::BYTE_W +: mps_pkg::BYTE_W]),
            .care_bit (cfg.care[k]),
            .byte_out (win[k]),
            .hit      (cell_hit[k])
        );
    end

    // First stage: byte position within the region and the window start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            flush_reg      <= 1'b1;
            bytes_seen_reg <= '0;
        end else if (s_accept) begin
            s1_valid_reg   <= 1'b1;
            flush_reg      <= s_tlast;
            bytes_seen_reg <= s_tlast ? '0 : bytes_seen_reg + mps_pkg::ADDR_W'(1);
        end else if (s2_fire) begin
            s1_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_last_reg   <= s_tlast;
            s1_pos_ok_reg <= bytes_seen_reg >=
                             mps_pkg::ADDR_W'(cfg.len - mps_pkg::LEN_W'(1));
            s1_off_reg    <= bytes_seen_reg + mps_pkg::ADDR_W'(1)
                             - mps_pkg::ADDR_W'(cfg.len);
        end
    end

    // Second stage: match counting and the result beat.
    assign window_hit = s1_pos_ok_reg & (&cell_hit);
    assign take       = ~done_reg & window_hit &
                        (matches_reg >= mps_pkg::CNT_W'(cfg.skip));
    assign not_found  = ~done_reg & s1_last_reg & ~take;

    always_comb begin
        matches_next = matches_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_found_next = m_found_reg;
        m_addr_next  = m_addr_reg;
        if (s2_fire) begin
            m_valid_next = take | not_found;
            m_found_next = take;
            m_addr_next  = take ? cfg.base + s1_off_reg : '0;
            if (take) begin
                done_next = 1'b1;
            end else if (~done_reg & window_hit) begin
                matches_next = matches_reg + mps_pkg::CNT_W'(1);
            end
            if (s1_last_reg) begin
                done_next    = 1'b0;
                matches_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matches_reg <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            matches_reg <= matches_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_addr_reg  <= m_addr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_found_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mps_checker.sv -----
// Port-level checks for the masked pattern scanner and their binding.
`timescale 1ns / 1ps
`default_nettype none

module mps_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [63:0]                       m_tdata,
    input  wire logic                              m_tuser
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A not-found beat carries a zero address.
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("not-found beat with nonzero address");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A fresh result rises only after an accepted input beat.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && aresetn, 2))
        else $error("result beat without a matching input beat");

endmodule

bind masked_pattern_scanner mps_checker u_mps_checker (.*);

`default_nettype wire
